// ===== rtl/fwpid_pkg.sv =====
// Shared widths, register map and lane types for the four-wheel PID speed control.
`timescale 1ns / 1ps

package fwpid_pkg;

  // Structural defaults.
  localparam int WHEELS_MAX          = 4;
  localparam int DEFAULT_WHEEL_COUNT = 4;
  localparam int DEFAULT_FRAC_BITS   = 8;

  // Field and datapath widths.
  localparam int DATA_W   = 16;  // target, delta and duty
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 23;
  localparam int OMAX_W   = 15;
  localparam int MASK_W   = 4;
  localparam int ERR_W    = 17;  // target minus delta
  localparam int DIFF_W   = 18;  // change in error
  localparam int PROD_W   = 34;  // gain times error
  localparam int DPROD_W  = 35;  // gain times change in error
  localparam int ACC_W    = 24;  // clamped integral, magnitude below 2^23
  localparam int ASUM_W   = 35;  // integral before clamping
  localparam int PD_W     = 36;  // P plus D
  localparam int SUM_W    = 37;  // P plus I plus D

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MAX     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEADZONE       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_POLARITY_MASK  = 3'd6;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  RST_GAIN_P         = 16'd256;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I         = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D         = 16'd0;
  localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT = 23'd0;
  localparam logic [OMAX_W-1:0]  RST_OUTPUT_MAX     = 15'd1000;
  localparam logic [OMAX_W-1:0]  RST_DEADZONE       = 15'd0;
  localparam logic [MASK_W-1:0]  RST_POLARITY_MASK  = 4'd0;

  // Settings that every lane needs.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [OMAX_W-1:0]  output_max;
  } lane_cfg_t;

  // Stage load strobes (each qualified by valid data) and the enable held at stage 2.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic en_s2;
  } lane_ctrl_t;

endpackage

// ===== rtl/fwpid_lane.sv =====
// One wheel's PID datapath: error, products, clamped integral and saturated duty.
`timescale 1ns / 1ps

module fwpid_lane #(
  parameter int FRAC_BITS = fwpid_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fwpid_pkg::lane_ctrl_t               ctrl_i,
  input  fwpid_pkg::lane_cfg_t                cfg_i,
  input  logic                                enable_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0] target_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0] delta_i,
  output logic signed [fwpid_pkg::DATA_W-1:0] duty_o
);

  localparam int ERR_W   = fwpid_pkg::ERR_W;
  localparam int DIFF_W  = fwpid_pkg::DIFF_W;
  localparam int PROD_W  = fwpid_pkg::PROD_W;
  localparam int DPROD_W = fwpid_pkg::DPROD_W;
  localparam int ACC_W   = fwpid_pkg::ACC_W;
  localparam int ASUM_W  = fwpid_pkg::ASUM_W;
  localparam int PD_W    = fwpid_pkg::PD_W;
  localparam int SUM_W   = fwpid_pkg::SUM_W;
  localparam int DATA_W  = fwpid_pkg::DATA_W;
  localparam int OMAX_W  = fwpid_pkg::OMAX_W;
  localparam int LIMIT_W = fwpid_pkg::LIMIT_W;
  localparam logic signed [SUM_W-1:0] FRAC_ONES =
    $signed(SUM_W'((64'd1 << FRAC_BITS) - 64'd1));

  // Stage 1: error and change in error.
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  prev_err_q;
  logic signed [ERR_W-1:0]  err1_q;
  logic signed [DIFF_W-1:0] diff1_q;

  assign err  = ERR_W'(target_i) - ERR_W'(delta_i);
  assign diff = DIFF_W'(err) - DIFF_W'(prev_err_q);

  // The last error is the derivative reference; a disabled tick clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (ctrl_i.ld1) begin
      prev_err_q <= enable_i ? err : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      err1_q  <= err;
      diff1_q <= diff;
    end
  end

  // Stage 2: one multiplier per term.
  localparam int GAIN_W_EXT = fwpid_pkg::GAIN_W + 1;
  logic signed [GAIN_W_EXT-1:0] gp_s, gi_s, gd_s;
  logic signed [PROD_W-1:0]  p2_q;
  logic signed [PROD_W-1:0]  i2_q;
  logic signed [DPROD_W-1:0] d2_q;

  assign gp_s = $signed({1'b0, cfg_i.gain_p});
  assign gi_s = $signed({1'b0, cfg_i.gain_i});
  assign gd_s = $signed({1'b0, cfg_i.gain_d});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      p2_q <= PROD_W'(gp_s) * PROD_W'(err1_q);
      i2_q <= PROD_W'(gi_s) * PROD_W'(err1_q);
      d2_q <= DPROD_W'(gd_s) * DPROD_W'(diff1_q);
    end
  end

  // Stage 3: integral accumulate and clamp; the accumulator is this stage's register.
  logic signed [ASUM_W-1:0] asum;
  logic signed [ASUM_W-1:0] lim;
  logic signed [ASUM_W-1:0] acc_next;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PD_W-1:0]   pd3_q;

  assign asum = ASUM_W'(acc_q) + ASUM_W'(i2_q);
  assign lim  = $signed({{(ASUM_W - LIMIT_W){1'b0}}, cfg_i.integral_limit});

  always_comb begin
    if (asum > lim) begin
      acc_next = lim;
    end else if (asum < -lim) begin
      acc_next = -lim;
    end else begin
      acc_next = asum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.ld3) begin
      acc_q <= ctrl_i.en_s2 ? ACC_W'(acc_next) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      pd3_q <= PD_W'(p2_q) + PD_W'(d2_q);
    end
  end

  // Stage 4: full sum, saturation at full precision, truncation toward zero.
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  omax_s;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  quot;
  logic signed [DATA_W-1:0] omax_d;
  logic signed [DATA_W-1:0] duty;
  logic signed [DATA_W-1:0] duty4_q;

  assign sum    = SUM_W'(pd3_q) + SUM_W'(acc_q);
  assign omax_s = $signed(SUM_W'({cfg_i.output_max, {FRAC_BITS{1'b0}}}));
  assign rnd    = sum + (sum[SUM_W-1] ? FRAC_ONES : '0);
  assign quot   = rnd >>> FRAC_BITS;
  assign omax_d = $signed({{(DATA_W - OMAX_W){1'b0}}, cfg_i.output_max});

  always_comb begin
    if (sum > omax_s) begin
      duty = omax_d;
    end else if (sum < -omax_s) begin
      duty = -omax_d;
    end else begin
      duty = quot[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld4) begin
      duty4_q <= duty;
    end
  end

  assign duty_o = duty4_q;

endmodule

// ===== rtl/four_wheel_pid_speed_control.sv =====
// Top level: configuration registers, pipeline control, wheel lanes and the output merge stage.
//
//   Channel  Direction  Handshake                       Payload
//   input    in         in_valid_i / in_ready_o         enable, target_a..d, delta_a..d
//   output   out        out_valid_o / out_ready_i       motors_on, duty_a..d
//   config   in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One request is taken per cycle while in_ready_o is high; results leave the merge stage.
// The last-error register in stage 1 and the integral add-and-clamp in stage 3 of each lane
// are the only loops across requests.
// Every stage loads whenever the stage after it is empty or moving, so a stalled output
// still lets requests enter until the pipeline is full.
// Reset clears valid bits, integral and last-error stores; config registers get reset values.
`timescale 1ns / 1ps

module four_wheel_pid_speed_control #(
  parameter int WHEEL_COUNT    = fwpid_pkg::DEFAULT_WHEEL_COUNT,
  parameter int GAIN_FRAC_BITS = fwpid_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Input channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    enable_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     target_a_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     target_b_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     target_c_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     target_d_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     delta_a_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     delta_b_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     delta_c_i,
  input  logic signed [fwpid_pkg::DATA_W-1:0]     delta_d_i,
  // Output channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    motors_on_o,
  output logic signed [fwpid_pkg::DATA_W-1:0]     duty_a_o,
  output logic signed [fwpid_pkg::DATA_W-1:0]     duty_b_o,
  output logic signed [fwpid_pkg::DATA_W-1:0]     duty_c_o,
  output logic signed [fwpid_pkg::DATA_W-1:0]     duty_d_o,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [fwpid_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [fwpid_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [fwpid_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);

  localparam int DATA_W     = fwpid_pkg::DATA_W;
  localparam int WHEELS_MAX = fwpid_pkg::WHEELS_MAX;
  localparam int OMAX_W     = fwpid_pkg::OMAX_W;
  localparam int APB_DATA_W = fwpid_pkg::APB_DATA_W;

  // Configuration registers.
  logic [fwpid_pkg::GAIN_W-1:0]    gain_p_q, gain_i_q, gain_d_q;
  logic [fwpid_pkg::LIMIT_W-1:0]   integral_limit_q;
  logic [OMAX_W-1:0]               output_max_q;
  logic [OMAX_W-1:0]               deadzone_q;
  logic [fwpid_pkg::MASK_W-1:0]    polarity_mask_q;
  logic [fwpid_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[fwpid_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= fwpid_pkg::RST_GAIN_P;
      gain_i_q         <= fwpid_pkg::RST_GAIN_I;
      gain_d_q         <= fwpid_pkg::RST_GAIN_D;
      integral_limit_q <= fwpid_pkg::RST_INTEGRAL_LIMIT;
      output_max_q     <= fwpid_pkg::RST_OUTPUT_MAX;
      deadzone_q       <= fwpid_pkg::RST_DEADZONE;
      polarity_mask_q  <= fwpid_pkg::RST_POLARITY_MASK;
    end else if (cfg_write) begin
      unique case (reg_idx)
        fwpid_pkg::REG_GAIN_P:         gain_p_q <= pwdata[fwpid_pkg::GAIN_W-1:0];
        fwpid_pkg::REG_GAIN_I:         gain_i_q <= pwdata[fwpid_pkg::GAIN_W-1:0];
        fwpid_pkg::REG_GAIN_D:         gain_d_q <= pwdata[fwpid_pkg::GAIN_W-1:0];
        fwpid_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= pwdata[fwpid_pkg::LIMIT_W-1:0];
        fwpid_pkg::REG_OUTPUT_MAX:     output_max_q <= pwdata[OMAX_W-1:0];
        fwpid_pkg::REG_DEADZONE:       deadzone_q <= pwdata[OMAX_W-1:0];
        fwpid_pkg::REG_POLARITY_MASK:  polarity_mask_q <= pwdata[fwpid_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      fwpid_pkg::REG_GAIN_P:         prdata = APB_DATA_W'(gain_p_q);
      fwpid_pkg::REG_GAIN_I:         prdata = APB_DATA_W'(gain_i_q);
      fwpid_pkg::REG_GAIN_D:         prdata = APB_DATA_W'(gain_d_q);
      fwpid_pkg::REG_INTEGRAL_LIMIT: prdata = APB_DATA_W'(integral_limit_q);
      fwpid_pkg::REG_OUTPUT_MAX:     prdata = APB_DATA_W'(output_max_q);
      fwpid_pkg::REG_DEADZONE:       prdata = APB_DATA_W'(deadzone_q);
      fwpid_pkg::REG_POLARITY_MASK:  prdata = APB_DATA_W'(polarity_mask_q);
      default:                       prdata = '0;
    endcase
  end

  // Pipeline occupancy; each stage may load when its successor is empty or moving.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1_q, en2_q, en3_q, en4_q;
  logic mv1, mv2, mv3, mv4, mv5;
  fwpid_pkg::lane_ctrl_t ctrl;

  assign mv5 = !v5_q || out_ready_i;
  assign mv4 = !v4_q || mv5;
  assign mv3 = !v3_q || mv4;
  assign mv2 = !v2_q || mv3;
  assign mv1 = !v1_q || mv2;
  assign in_ready_o = mv1;

  assign ctrl.ld1   = in_valid_i && mv1;
  assign ctrl.ld2   = v1_q && mv2;
  assign ctrl.ld3   = v2_q && mv3;
  assign ctrl.ld4   = v3_q && mv4;
  assign ctrl.en_s2 = en2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (mv1) begin
        v1_q <= in_valid_i;
      end
      if (mv2) begin
        v2_q <= v1_q;
      end
      if (mv3) begin
        v3_q <= v2_q;
      end
      if (mv4) begin
        v4_q <= v3_q;
      end
      if (mv5) begin
        v5_q <= v4_q;
      end
    end
  end

  // Enable flag travels alongside the lane data.
  always_ff @(posedge clk_i) begin
    if (ctrl.ld1) begin
      en1_q <= enable_i;
    end
    if (ctrl.ld2) begin
      en2_q <= en1_q;
    end
    if (ctrl.ld3) begin
      en3_q <= en2_q;
    end
    if (ctrl.ld4) begin
      en4_q <= en3_q;
    end
  end

  // Wheel lanes.
  fwpid_pkg::lane_cfg_t lane_cfg;
  logic signed [DATA_W-1:0] target[WHEELS_MAX];
  logic signed [DATA_W-1:0] delta[WHEELS_MAX];
  logic signed [DATA_W-1:0] lane_duty[WHEELS_MAX];

  assign lane_cfg.gain_p         = gain_p_q;
  assign lane_cfg.gain_i         = gain_i_q;
  assign lane_cfg.gain_d         = gain_d_q;
  assign lane_cfg.integral_limit = integral_limit_q;
  assign lane_cfg.output_max     = output_max_q;

  assign target[0] = target_a_i;
  assign target[1] = target_b_i;
  assign target[2] = target_c_i;
  assign target[3] = target_d_i;
  assign delta[0]  = delta_a_i;
  assign delta[1]  = delta_b_i;
  assign delta[2]  = delta_c_i;
  assign delta[3]  = delta_d_i;

  for (genvar w = 0; w < WHEELS_MAX; w++) begin : g_lane
    if (w < WHEEL_COUNT) begin : g_on
      fwpid_lane #(
        .FRAC_BITS(GAIN_FRAC_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .cfg_i    (lane_cfg),
        .enable_i (enable_i),
        .target_i (target[w]),
        .delta_i  (delta[w]),
        .duty_o   (lane_duty[w])
      );
    end else begin : g_off
      assign lane_duty[w] = '0;
    end
  end

  // Merge stage: deadzone lift, polarity and the enable gate.
  logic signed [DATA_W-1:0] dz;
  logic signed [DATA_W-1:0] merged[WHEELS_MAX];
  logic signed [DATA_W-1:0] duty5_q[WHEELS_MAX];
  logic                     motors5_q;

  assign dz = $signed({{(DATA_W - OMAX_W){1'b0}}, deadzone_q});

  always_comb begin
    for (int w = 0; w < WHEELS_MAX; w++) begin
      merged[w] = lane_duty[w];
      if (merged[w] > 0 && merged[w] < dz) begin
        merged[w] = dz;
      end else if (merged[w] < 0 && merged[w] > -dz) begin
        merged[w] = -dz;
      end
      if (polarity_mask_q[w]) begin
        merged[w] = -merged[w];
      end
      if (!en4_q) begin
        merged[w] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && mv5) begin
      motors5_q <= en4_q;
      for (int w = 0; w < WHEELS_MAX; w++) begin
        duty5_q[w] <= merged[w];
      end
    end
  end

  assign out_valid_o = v5_q;
  assign motors_on_o = motors5_q;
  assign duty_a_o    = duty5_q[0];
  assign duty_b_o    = duty5_q[1];
  assign duty_c_o    = duty5_q[2];
  assign duty_d_o    = duty5_q[3];

endmodule

// ===== rtl/fwpid_checker.sv =====
// Port-level checks for the four-wheel PID speed control, bound to the top level.
`timescale 1ns / 1ps

module fwpid_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               motors_on_o,
  input logic [fwpid_pkg::DATA_W-1:0]       duty_a_o,
  input logic [fwpid_pkg::DATA_W-1:0]       duty_b_o,
  input logic [fwpid_pkg::DATA_W-1:0]       duty_c_o,
  input logic [fwpid_pkg::DATA_W-1:0]       duty_d_o,
  input logic                               pready
);

  localparam logic [fwpid_pkg::DATA_W-1:0] MOST_NEG = 16'h8000;

  // The register port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motors_on_o) &&
      $stable(duty_a_o) && $stable(duty_b_o) && $stable(duty_c_o) && $stable(duty_d_o))
    else $error("stalled result changed");

  // Motors off means every duty is zero.
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !motors_on_o |->
      duty_a_o == '0 && duty_b_o == '0 && duty_c_o == '0 && duty_d_o == '0)
    else $error("nonzero duty with motors off");

  // Saturation and polarity keep the duty symmetric, so the most negative code never shows.
  a_duty_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_a_o != MOST_NEG && duty_b_o != MOST_NEG &&
      duty_c_o != MOST_NEG && duty_d_o != MOST_NEG)
    else $error("duty outside symmetric range");

endmodule

bind four_wheel_pid_speed_control fwpid_checker u_fwpid_checker (.*);
